@@ src/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

    localparam int Q_W = 16;
    localparam int N_W = 17;

    // Which output slot receives the root-derived main component.
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_W = 2'd3;

    typedef struct packed {
        logic signed [Q_W-1:0] r00;
        logic signed [Q_W-1:0] r01;
        logic signed [Q_W-1:0] r02;
        logic signed [Q_W-1:0] r10;
        logic signed [Q_W-1:0] r11;
        logic signed [Q_W-1:0] r12;
        logic signed [Q_W-1:0] r20;
        logic signed [Q_W-1:0] r21;
        logic signed [Q_W-1:0] r22;
    } matrix_t;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic signed [Q_W-1:0] qz;
        logic signed [Q_W-1:0] qw;
    } quat_t;

endpackage

@@ src/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RTW = 16,
    parameter int PW  = 53
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  logic [2*RTW-1:0]     rad_in,
    input  logic [PW-1:0]        pay_in,
    output logic                 vld_out,
    output logic [RTW-1:0]       root,
    output logic [PW-1:0]        pay_out
);

    localparam int RW = 2 * RTW;

    logic [RTW+1:0] rem_reg [RTW];
    logic [RTW-1:0] res_reg [RTW];
    logic [RW-1:0]  rad_reg [RTW];
    logic [PW-1:0]  pay_reg [RTW];
    logic           vld_reg [RTW];

    for (genvar s = 0; s < RTW; s++) begin : g_stage
        logic [RTW+1:0] rem_prev;
        logic [RTW-1:0] res_prev;
        logic [RW-1:0]  rad_prev;
        logic [PW-1:0]  pay_prev;
        logic           vld_prev;
        logic [RTW+1:0] rem_sh;
        logic [RTW+1:0] trial;
        logic [RTW+1:0] rem_next;
        logic [RTW-1:0] res_next;

        if (s == 0) begin : g_first
            assign rem_prev = '0;
            assign res_prev = '0;
            assign rad_prev = rad_in;
            assign pay_prev = pay_in;
            assign vld_prev = vld_in;
        end
        else begin : g_next
            assign rem_prev = rem_reg[s-1];
            assign res_prev = res_reg[s-1];
            assign rad_prev = rad_reg[s-1];
            assign pay_prev = pay_reg[s-1];
            assign vld_prev = vld_reg[s-1];
        end

        // Bring down the next radicand bit pair and try appending a one.
        assign rem_sh = {rem_prev[RTW-1:0], rad_prev[RW-1-2*s -: 2]};
        assign trial  = {res_prev, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                res_next = {res_prev[RTW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                res_next = {res_prev[RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            res_reg[s] <= res_next;
            rad_reg[s] <= rad_prev;
            pay_reg[s] <= pay_prev;
        end
    end

    assign vld_out = vld_reg[RTW-1];
    assign root    = res_reg[RTW-1];
    assign pay_out = pay_reg[RTW-1];

endmodule

@@ src/rmq_div.sv @@
// Three-lane pipelined divider: rounded n * 2^FRAC_BITS / (2r) with saturation.
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int RTW       = 16,
    parameter int PW        = 18
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld_in,
    input  logic [RTW-1:0]        root,
    input  logic [2:0][N_W-1:0]   num_in,
    input  logic [PW-1:0]         pay_in,
    output logic                  vld_out,
    output logic [2:0][Q_W-1:0]   quo,
    output logic [PW-1:0]         pay_out
);

    localparam int NW0 = (Q_W + FRAC_BITS > RTW) ? Q_W + FRAC_BITS : RTW;
    localparam int NW  = NW0 + 1;
    localparam int CW  = (NW > RTW + Q_W + 1) ? NW : RTW + Q_W + 1;
    localparam int NST = Q_W + 1;

    logic [2:0][CW-1:0]  rem_reg [NST];
    logic [2:0][Q_W-1:0] q_reg   [NST];
    logic [2:0]          neg_reg [NST];
    logic [2:0]          ovf_reg [NST];
    logic [CW-1:0]       den_reg [NST];
    logic [PW-1:0]       pay_reg [NST];
    logic                vld_reg [NST];

    // Stage 0: magnitude, rounding bias, and the overflow check.
    logic [2:0][CW-1:0] rem0_next;
    logic [2:0]         neg0_next;
    logic [2:0]         ovf0_next;
    logic [CW-1:0]      den0_next;

    assign den0_next = CW'({root, 1'b0});

    for (genvar l = 0; l < 3; l++) begin : g_lane0
        logic [N_W-1:0] mag;
        assign neg0_next[l] = num_in[l][N_W-1];
        assign mag          = num_in[l][N_W-1] ? (~num_in[l] + N_W'(1)) : num_in[l];
        assign rem0_next[l] = (CW'(mag) << FRAC_BITS) + CW'(root);
        assign ovf0_next[l] = rem0_next[l] >= (den0_next << Q_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem0_next;
        q_reg[0]   <= '0;
        neg_reg[0] <= neg0_next;
        ovf_reg[0] <= ovf0_next;
        den_reg[0] <= den0_next;
        pay_reg[0] <= pay_in;
    end

    // Stages 1..16 each settle one quotient bit, from the top down.
    for (genvar s = 1; s < NST; s++) begin : g_stage
        localparam int B = Q_W - s;
        logic [2:0][CW-1:0]  rem_next;
        logic [2:0][Q_W-1:0] q_next;
        logic [CW-1:0]       dsh;

        assign dsh = den_reg[s-1] << B;

        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_comb
            begin
                q_next[l] = q_reg[s-1][l];
                if (rem_reg[s-1][l] >= dsh)
                begin
                    rem_next[l]  = rem_reg[s-1][l] - dsh;
                    q_next[l][B] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_reg[s-1][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            q_reg[s]   <= q_next;
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            den_reg[s] <= den_reg[s-1];
            pay_reg[s] <= pay_reg[s-1];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_sat
        logic [Q_W-1:0] q;
        logic           ovf;
        assign q   = q_reg[NST-1][l];
        assign ovf = ovf_reg[NST-1][l];
        always_comb
        begin
            if (!neg_reg[NST-1][l])
                quo[l] = (ovf || q[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : q;
            else if (ovf || q > {1'b1, {(Q_W-1){1'b0}}})
                quo[l] = {1'b1, {(Q_W-1){1'b0}}};
            else
                quo[l] = ~q + Q_W'(1);
        end
    end

    assign vld_out = vld_reg[NST-1];
    assign pay_out = pay_reg[NST-1];

endmodule

@@ src/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix to unit quaternion converter, fully pipelined.
// Path: input register, radicand register, one square-root stage per root bit (RTW is
// the root width), divider stage 0, one divider stage per quotient bit, output register.
// Throughput: one item per cycle; busy is always low and results cannot be held off.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  matrix_t matrix,
    output logic    done,
    output quat_t   quat
);

    localparam int DW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int SW  = DW + 1;
    localparam int RTW = (DW + FRAC_BITS + 1) / 2;
    localparam int RW  = 2 * RTW;
    localparam int MW  = ((RTW > Q_W) ? RTW : Q_W) + 1;
    localparam int SPW = 2 + 3 * N_W;
    localparam int DPW = 2 + Q_W;
    localparam int LAT = RTW + Q_W + 4;
    localparam logic [SW-1:0] ONE_U =
        {{(SW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    assign busy = 1'b0;

    // Input register.
    matrix_t in_reg;
    logic    in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= matrix;
    end

    // Branch selection, radicand and the three numerators.
    logic signed [Q_W+1:0] tr;
    logic signed [Q_W+1:0] dg;
    logic signed [SW-1:0]  d_s;
    logic [1:0]            sel;
    logic [1:0]            diag_i;
    logic signed [N_W-1:0] n0, n1, n2;
    logic [DW-1:0]         d_u;

    assign tr = (Q_W+2)'(in_reg.r00) + (Q_W+2)'(in_reg.r11) + (Q_W+2)'(in_reg.r22);

    always_comb
    begin
        diag_i = SEL_X;
        if (in_reg.r11 > in_reg.r00)
            diag_i = SEL_Y;
        if ((diag_i == SEL_Y) ? (in_reg.r22 > in_reg.r11) : (in_reg.r22 > in_reg.r00))
            diag_i = SEL_Z;
    end

    always_comb
    begin
        sel = (tr > 0) ? SEL_W : diag_i;
        dg  = '0;
        n0  = N_W'(in_reg.r21) - N_W'(in_reg.r12);
        n1  = N_W'(in_reg.r02) - N_W'(in_reg.r20);
        n2  = N_W'(in_reg.r10) - N_W'(in_reg.r01);
        unique case (sel)
            SEL_W:
            begin
                dg = tr;
            end
            SEL_X:
            begin
                dg = (Q_W+2)'(in_reg.r00) - (Q_W+2)'(in_reg.r11) - (Q_W+2)'(in_reg.r22);
                n0 = N_W'(in_reg.r21) - N_W'(in_reg.r12);
                n1 = N_W'(in_reg.r10) + N_W'(in_reg.r01);
                n2 = N_W'(in_reg.r20) + N_W'(in_reg.r02);
            end
            SEL_Y:
            begin
                dg = (Q_W+2)'(in_reg.r11) - (Q_W+2)'(in_reg.r22) - (Q_W+2)'(in_reg.r00);
                n0 = N_W'(in_reg.r02) - N_W'(in_reg.r20);
                n1 = N_W'(in_reg.r21) + N_W'(in_reg.r12);
                n2 = N_W'(in_reg.r01) + N_W'(in_reg.r10);
            end
            SEL_Z:
            begin
                dg = (Q_W+2)'(in_reg.r22) - (Q_W+2)'(in_reg.r00) - (Q_W+2)'(in_reg.r11);
                n0 = N_W'(in_reg.r10) - N_W'(in_reg.r01);
                n1 = N_W'(in_reg.r02) + N_W'(in_reg.r20);
                n2 = N_W'(in_reg.r12) + N_W'(in_reg.r21);
            end
            default:
            begin
                dg = tr;
            end
        endcase
    end

    // A radicand below one raw unit only comes from a non-rotation; clamp it.
    assign d_s = $signed(ONE_U) + SW'(dg);
    assign d_u = (d_s < SW'(1)) ? DW'(1) : d_s[DW-1:0];

    logic           prep_vld_reg;
    logic [RW-1:0]  rad_reg;
    logic [SPW-1:0] spay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_vld_reg <= 1'b0;
        else
            prep_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= RW'({d_u, {FRAC_BITS{1'b0}}});
        spay_reg <= {sel, n0, n1, n2};
    end

    // Square root.
    logic           sq_vld;
    logic [RTW-1:0] sq_root;
    logic [SPW-1:0] sq_pay;

    rmq_sqrt #(
        .RTW (RTW),
        .PW  (SPW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (prep_vld_reg),
        .rad_in  (rad_reg),
        .pay_in  (spay_reg),
        .vld_out (sq_vld),
        .root    (sq_root),
        .pay_out (sq_pay)
    );

    // Main component is the root halved, rounded up on ties.
    logic [MW-1:0]      main_w;
    logic [Q_W-1:0]     main_q;
    logic [2:0][N_W-1:0] dnum;

    assign main_w = (MW'(sq_root) + MW'(1)) >> 1;
    assign main_q = (main_w > MW'(32767)) ? Q_W'(32767) : main_w[Q_W-1:0];
    assign dnum[0] = sq_pay[3*N_W-1 -: N_W];
    assign dnum[1] = sq_pay[2*N_W-1 -: N_W];
    assign dnum[2] = sq_pay[N_W-1:0];

    logic                dv_vld;
    logic [2:0][Q_W-1:0] dv_quo;
    logic [DPW-1:0]      dv_pay;

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .RTW       (RTW),
        .PW        (DPW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sq_vld),
        .root    (sq_root),
        .num_in  (dnum),
        .pay_in  ({sq_pay[SPW-1 -: 2], main_q}),
        .vld_out (dv_vld),
        .quo     (dv_quo),
        .pay_out (dv_pay)
    );

    // Route lanes back to their quaternion slots.
    quat_t          quat_next;
    logic [1:0]     osel;
    logic [Q_W-1:0] omain;

    assign osel  = dv_pay[DPW-1 -: 2];
    assign omain = dv_pay[Q_W-1:0];

    always_comb
    begin
        unique case (osel)
            SEL_W:   quat_next = {dv_quo[0], dv_quo[1], dv_quo[2], omain};
            SEL_X:   quat_next = {omain, dv_quo[1], dv_quo[2], dv_quo[0]};
            SEL_Y:   quat_next = {dv_quo[2], omain, dv_quo[1], dv_quo[0]};
            SEL_Z:   quat_next = {dv_quo[1], dv_quo[2], omain, dv_quo[0]};
            default: quat_next = {dv_quo[0], dv_quo[1], dv_quo[2], omain};
        endcase
    end

    logic  done_reg;
    quat_t quat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

`ifndef SYNTH
    a_sqrt_lat: assert property (@(posedge clk) disable iff (!rst_n)
        prep_vld_reg |-> ##RTW sq_vld)
        else $error("square root stage lost an item");

    a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld |-> ##(Q_W+1) dv_vld)
        else $error("divider stage lost an item");

    a_e2e_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item did not complete on time");
`endif

endmodule
